/* design/qoid_pkg.sv */
// ----------------------------------------------------------------------------
// qoid_pkg
// Shared types and constants for the QOI image stream decoder.
// ----------------------------------------------------------------------------
package qoid_pkg;

   // The four magic bytes "qoif", first byte in the top bits.
   localparam logic [31:0] QOI_MAGIC = 32'h716F6966;
   localparam logic [3:0]  HEADER_LAST = 4'd13;
   localparam logic [7:0]  TAG_RGB = 8'hFE;
   localparam logic [7:0]  TAG_RGBA = 8'hFF;

   // Two-bit chunk opcodes of the single-byte tags.
   localparam logic [1:0] OP_INDEX = 2'd0;
   localparam logic [1:0] OP_DIFF  = 2'd1;
   localparam logic [1:0] OP_LUMA  = 2'd2;
   localparam logic [1:0] OP_RUN   = 2'd3;

   typedef enum logic [1:0] {
      STATUS_PIXEL     = 2'd0,
      STATUS_BAD_MAGIC = 2'd1,
      STATUS_RUN_LONG  = 2'd2
   } status_type;

   // Position inside a multi-byte chunk.
   typedef enum logic [2:0] {
      PH_TAG  = 3'd0,
      PH_R    = 3'd1,
      PH_G    = 3'd2,
      PH_B    = 3'd3,
      PH_A    = 3'd4,
      PH_LUMA = 3'd5
   } phase_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_IDXRD = 2'd1,
      ST_EMIT  = 2'd2,
      ST_ERR   = 2'd3
   } state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_start;
   } in_item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      status_type status;
      logic       last_of_run;
      logic       image_done;
   } out_item_type;

   // Expected magic byte at header position 0..3.
   function automatic logic [7:0] magic_byte(input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0: b = QOI_MAGIC[31:24];
         2'd1: b = QOI_MAGIC[23:16];
         2'd2: b = QOI_MAGIC[15:8];
         default: b = QOI_MAGIC[7:0];
      endcase
      return b;
   endfunction

endpackage

/* design/qoi_image_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// qoi_image_stream_decoder_unit
// QOI stream decoder: byte queue in front, chunk decoder behind it, and a
// result queue toward the pixel sink.
// ----------------------------------------------------------------------------
//  Channel   Handshake     Word
//  req_      push / full   data_byte, stream_start
//  rsp_      pop / empty   red, green, blue, alpha, status, last_of_run,
//                          image_done
//
//  Header bytes and RGB/RGBA/LUMA data bytes are taken in the idle state.
//  A pixel byte goes on to the emit state, an INDEX chunk first to the index
//  read state (registered index memory read). A run writes one result per
//  cycle unless the result queue is full. A start word first clears state.
//  Reset is synchronous; afterwards the decoder ignores bytes until a start.
//  The byte queue keeps taking words while the decoder or the result side
//  stalls, until it is full.
module qoi_image_stream_decoder_unit #(
   parameter int InDepth  = 4,
   parameter int OutDepth = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_data_byte,
   input  logic       req_stream_start,
   input  logic       push,
   output logic       full,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic [7:0] rsp_alpha,
   output logic [1:0] rsp_status,
   output logic       rsp_last_of_run,
   output logic       rsp_image_done,
   output logic       empty,
   input  logic       pop
);
   qoid_pkg::in_item_type  in_wr, in_rd;
   qoid_pkg::out_item_type out_wr, out_rd;
   logic in_empty, in_pop, out_full, out_push;

   assign in_wr = '{data_byte: req_data_byte, stream_start: req_stream_start};

   qoid_queue #(.item_type(qoid_pkg::in_item_type), .Depth(InDepth)) u_in_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .wr_data (in_wr),
      .pop     (in_pop),
      .empty   (in_empty),
      .rd_data (in_rd)
   );

   qoid_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_item  (in_rd),
      .in_empty (in_empty),
      .in_pop   (in_pop),
      .out_item (out_wr),
      .out_full (out_full),
      .out_push (out_push)
   );

   qoid_queue #(.item_type(qoid_pkg::out_item_type), .Depth(OutDepth)) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .full    (out_full),
      .wr_data (out_wr),
      .pop     (pop),
      .empty   (empty),
      .rd_data (out_rd)
   );

   assign rsp_red         = out_rd.red;
   assign rsp_green       = out_rd.green;
   assign rsp_blue        = out_rd.blue;
   assign rsp_alpha       = out_rd.alpha;
   assign rsp_status      = out_rd.status;
   assign rsp_last_of_run = out_rd.last_of_run;
   assign rsp_image_done  = out_rd.image_done;

endmodule

/* design/qoid_queue.sv */
// ----------------------------------------------------------------------------
// qoid_queue
// Small first-in first-out queue of words with full and empty flags.
// ----------------------------------------------------------------------------
module qoid_queue #(
   parameter type item_type = logic,
   parameter int  Depth = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type wr_data,
   input  logic     pop,
   output logic     empty,
   output item_type rd_data
);
   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type            store_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   // Pointer and fill count updates with explicit wrap.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Word storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* design/qoid_decode.sv */
// ----------------------------------------------------------------------------
// qoid_decode
// Back end: parses the header and chunks, keeps the previous pixel and the
// colour index, and writes one result word per decoded pixel or error.
// ----------------------------------------------------------------------------
module qoid_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  qoid_pkg::in_item_type in_item,
   input  logic                  in_empty,
   output logic                  in_pop,
   output qoid_pkg::out_item_type out_item,
   input  logic                  out_full,
   output logic                  out_push
);
   qoid_pkg::state_type  state_ff, state_in;
   qoid_pkg::phase_type  phase_ff, phase_in;
   qoid_pkg::status_type err_ff, err_in;
   logic [3:0]  hdr_pos_ff, hdr_pos_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  dg_ff, dg_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [63:0] left_ff, left_in;
   logic [31:0] prev_ff, prev_in;
   logic [63:0] valid_ff, valid_in;
   logic        halted_ff, halted_in;
   logic        restarted_ff, restarted_in;
   logic [5:0]  run_ff, run_in;
   logic [31:0] rd_ff;
   logic        rd_valid_ff;
   logic [31:0] index_mem [64];

   logic        act, do_restart, proc;
   logic        mem_we, rd_en;
   logic [7:0]  byte_v, r, g, b, a;
   logic [12:0] hash_sum;
   logic [5:0]  hash;
   logic [6:0]  run_len;

   assign byte_v   = in_item.data_byte;
   assign r        = prev_ff[31:24];
   assign g        = prev_ff[23:16];
   assign b        = prev_ff[15:8];
   assign a        = prev_ff[7:0];
   assign hash_sum = 13'(r) * 13'd3 + 13'(g) * 13'd5 + 13'(b) * 13'd7 + 13'(a) * 13'd11;
   assign hash     = hash_sum[5:0];
   assign run_len  = 7'(byte_v[5:0]) + 7'd1;

   // A start word first clears the stream state, then is parsed next cycle.
   assign act        = (state_ff == qoid_pkg::ST_IDLE) && !in_empty;
   assign do_restart = act && in_item.stream_start && !restarted_ff;
   assign proc       = act && !do_restart;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qoid_pkg::ST_IDLE: begin
            if (proc && !halted_ff) begin
               if (hdr_pos_ff <= qoid_pkg::HEADER_LAST) begin
                  if (hdr_pos_ff < 4'd4 &&
                      byte_v != qoid_pkg::magic_byte(hdr_pos_ff[1:0])) begin
                     state_in = qoid_pkg::ST_ERR;
                  end
               end else if (left_ff != '0) begin
                  priority case (phase_ff)
                     qoid_pkg::PH_R, qoid_pkg::PH_G: state_in = qoid_pkg::ST_IDLE;
                     qoid_pkg::PH_B: begin
                        if (tag_ff != qoid_pkg::TAG_RGBA) state_in = qoid_pkg::ST_EMIT;
                     end
                     qoid_pkg::PH_A, qoid_pkg::PH_LUMA: state_in = qoid_pkg::ST_EMIT;
                     default: begin
                        if (byte_v != qoid_pkg::TAG_RGBA && byte_v != qoid_pkg::TAG_RGB) begin
                           unique case (byte_v[7:6])
                              qoid_pkg::OP_INDEX: state_in = qoid_pkg::ST_IDXRD;
                              qoid_pkg::OP_DIFF:  state_in = qoid_pkg::ST_EMIT;
                              qoid_pkg::OP_LUMA:  state_in = qoid_pkg::ST_IDLE;
                              default: begin
                                 if (64'(run_len) > left_ff) state_in = qoid_pkg::ST_ERR;
                                 else state_in = qoid_pkg::ST_EMIT;
                              end
                           endcase
                        end
                     end
                  endcase
               end
            end
         end
         qoid_pkg::ST_IDXRD: state_in = qoid_pkg::ST_EMIT;
         qoid_pkg::ST_EMIT: begin
            if (!out_full && run_ff == '0) state_in = qoid_pkg::ST_IDLE;
         end
         default: begin
            if (!out_full) state_in = qoid_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath updates and outputs.
   always_comb begin
      phase_in     = phase_ff;
      err_in       = err_ff;
      hdr_pos_in   = hdr_pos_ff;
      tag_in       = tag_ff;
      dg_in        = dg_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      left_in      = left_ff;
      prev_in      = prev_ff;
      valid_in     = valid_ff;
      halted_in    = halted_ff;
      restarted_in = restarted_ff;
      run_in       = run_ff;
      in_pop       = proc;
      out_push     = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      out_item     = '{red: r, green: g, blue: b, alpha: a,
                       status: qoid_pkg::STATUS_PIXEL,
                       last_of_run: (run_ff == '0),
                       image_done: (left_ff == 64'd1)};

      unique case (state_ff)
         qoid_pkg::ST_IDLE: begin
            if (do_restart) begin
               phase_in     = qoid_pkg::PH_TAG;
               hdr_pos_in   = '0;
               tag_in       = '0;
               dg_in        = '0;
               width_in     = '0;
               height_in    = '0;
               left_in      = '0;
               prev_in      = 32'h0000_00FF;
               valid_in     = '0;
               halted_in    = 1'b0;
               restarted_in = 1'b1;
            end else if (proc) begin
               restarted_in = 1'b0;
               if (!halted_ff) begin
                  if (hdr_pos_ff <= qoid_pkg::HEADER_LAST) begin
                     // Header: magic, width, height, then two ignored bytes.
                     if (hdr_pos_ff < 4'd4 &&
                         byte_v != qoid_pkg::magic_byte(hdr_pos_ff[1:0])) begin
                        err_in    = qoid_pkg::STATUS_BAD_MAGIC;
                        halted_in = 1'b1;
                     end else begin
                        hdr_pos_in = hdr_pos_ff + 4'd1;
                        if (hdr_pos_ff >= 4'd4 && hdr_pos_ff < 4'd8) begin
                           width_in = {width_ff[23:0], byte_v};
                        end else if (hdr_pos_ff >= 4'd8 && hdr_pos_ff < 4'd12) begin
                           height_in = {height_ff[23:0], byte_v};
                        end
                        if (hdr_pos_ff == qoid_pkg::HEADER_LAST) begin
                           left_in = 64'(width_ff) * 64'(height_ff);
                        end
                     end
                  end else if (left_ff != '0) begin
                     run_in = '0;
                     priority case (phase_ff)
                        qoid_pkg::PH_R: begin
                           prev_in[31:24] = byte_v;
                           phase_in = qoid_pkg::PH_G;
                        end
                        qoid_pkg::PH_G: begin
                           prev_in[23:16] = byte_v;
                           phase_in = qoid_pkg::PH_B;
                        end
                        qoid_pkg::PH_B: begin
                           prev_in[15:8] = byte_v;
                           phase_in = (tag_ff == qoid_pkg::TAG_RGBA) ?
                                      qoid_pkg::PH_A : qoid_pkg::PH_TAG;
                        end
                        qoid_pkg::PH_A: begin
                           prev_in[7:0] = byte_v;
                           phase_in = qoid_pkg::PH_TAG;
                        end
                        qoid_pkg::PH_LUMA: begin
                           prev_in[31:24] = r + dg_ff + 8'(byte_v[7:4]) - 8'd8;
                           prev_in[23:16] = g + dg_ff;
                           prev_in[15:8]  = b + dg_ff + 8'(byte_v[3:0]) - 8'd8;
                           phase_in = qoid_pkg::PH_TAG;
                        end
                        default: begin
                           // Awaiting a tag; unused phase codes land here too.
                           phase_in = qoid_pkg::PH_TAG;
                           tag_in   = byte_v;
                           if (byte_v == qoid_pkg::TAG_RGBA || byte_v == qoid_pkg::TAG_RGB) begin
                              phase_in = qoid_pkg::PH_R;
                           end else begin
                              unique case (byte_v[7:6])
                                 qoid_pkg::OP_INDEX: rd_en = 1'b1;
                                 qoid_pkg::OP_DIFF: begin
                                    prev_in[31:24] = r + 8'(byte_v[5:4]) - 8'd2;
                                    prev_in[23:16] = g + 8'(byte_v[3:2]) - 8'd2;
                                    prev_in[15:8]  = b + 8'(byte_v[1:0]) - 8'd2;
                                 end
                                 qoid_pkg::OP_LUMA: begin
                                    dg_in    = 8'(byte_v[5:0]) - 8'd32;
                                    phase_in = qoid_pkg::PH_LUMA;
                                 end
                                 default: begin
                                    if (64'(run_len) > left_ff) begin
                                       err_in    = qoid_pkg::STATUS_RUN_LONG;
                                       halted_in = 1'b1;
                                    end else begin
                                       run_in = byte_v[5:0];
                                    end
                                 end
                              endcase
                           end
                        end
                     endcase
                  end
               end
            end
         end
         qoid_pkg::ST_IDXRD: begin
            prev_in = rd_valid_ff ? rd_ff : '0;
         end
         qoid_pkg::ST_EMIT: begin
            // One pixel per cycle while the result queue is not full; the index is updated with each one.
            if (!out_full) begin
               out_push       = 1'b1;
               mem_we         = 1'b1;
               valid_in[hash] = 1'b1;
               left_in        = left_ff - 64'd1;
               if (run_ff != '0) run_in = run_ff - 6'd1;
            end
         end
         default: begin
            out_item = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0,
                         status: err_ff, last_of_run: 1'b1, image_done: 1'b0};
            out_push = !out_full;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qoid_pkg::ST_IDLE;
         phase_ff     <= qoid_pkg::PH_TAG;
         hdr_pos_ff   <= '0;
         left_ff      <= '0;
         valid_ff     <= '0;
         halted_ff    <= 1'b1;
         restarted_ff <= 1'b0;
         run_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         hdr_pos_ff   <= hdr_pos_in;
         left_ff      <= left_in;
         valid_ff     <= valid_in;
         halted_ff    <= halted_in;
         restarted_ff <= restarted_in;
         run_ff       <= run_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      err_ff    <= err_in;
      tag_ff    <= tag_in;
      dg_ff     <= dg_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      prev_ff   <= prev_in;
   end

   // Colour index memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         index_mem[hash] <= prev_ff;
      end
      if (rd_en) begin
         rd_ff       <= index_mem[byte_v[5:0]];
         rd_valid_ff <= valid_ff[byte_v[5:0]];
      end
   end

endmodule
